/* rtl/ir_pulse_distance_decoder_unit_assert.svh */
// Assertion macros shared by the pulse-distance decoder RTL.
// Depends on nothing; files that assert include it by bare name and supply clk and rst.
`ifndef IR_PULSE_DISTANCE_DECODER_UNIT_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IRPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irpd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IRPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irpd assertion failed");

`endif

/* rtl/irpd_pkg.sv */
// Shared types and constants for the pulse-distance decoder.
// Depends on nothing; every RTL module refers to it by scoped names.
package irpd_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam logic [5:0]  FRAME_COUNT = 6'd32;
  localparam logic [5:0]  LAST_BIT = 6'd31;
  localparam logic [6:0]  DUTY_STEP = 7'd10;
  localparam logic [6:0]  DUTY_MAX = 7'd100;
  localparam logic [6:0]  DUTY_HIGH_LIMIT = 7'd90;

  localparam logic [15:0] HEADER_MIN_RESET = 16'd850;
  localparam logic [15:0] HEADER_MAX_RESET = 16'd950;
  localparam logic [15:0] ONE_THRESHOLD_RESET = 16'd160;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_MODE    = 3'd1,
    ACT_UP      = 3'd2,
    ACT_DOWN    = 3'd3,
    ACT_HALT    = 3'd4,
    ACT_UNKNOWN = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    REG_DEVICE_ADDRESS = 4'd0,
    REG_MODE_CODES     = 4'd1,
    REG_UP_CODES       = 4'd2,
    REG_DOWN_CODES     = 4'd3,
    REG_POWER_CODE     = 4'd4,
    REG_HEADER_MIN     = 4'd5,
    REG_HEADER_MAX     = 4'd6,
    REG_ONE_THRESHOLD  = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0] device_address;
    logic [63:0] mode_codes;
    logic [31:0] up_codes;
    logic [31:0] down_codes;
    logic [15:0] power_code;
    logic [15:0] header_min;
    logic [15:0] header_max;
    logic [15:0] one_threshold;
  } cfg_t;

  typedef struct packed {
    logic        done;
    logic [31:0] code;
  } frame_evt_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  mode;
    logic [6:0]  duty;
  } cmd_result_t;

endpackage

/* rtl/irpd_cfg_regs.sv */
// Configuration register file of the pulse-distance decoder.
// Depends on irpd_pkg for the register indexes and the cfg_t bundle.
module irpd_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [3:0]        wr_index,
  input  logic [63:0]       wr_data,
  output irpd_pkg::cfg_t    cfg
);

  irpd_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.device_address <= '0;
      regs.mode_codes     <= '0;
      regs.up_codes       <= '0;
      regs.down_codes     <= '0;
      regs.power_code     <= '0;
      regs.header_min     <= irpd_pkg::HEADER_MIN_RESET;
      regs.header_max     <= irpd_pkg::HEADER_MAX_RESET;
      regs.one_threshold  <= irpd_pkg::ONE_THRESHOLD_RESET;
    end else if (wr_en) begin
      // Indexes past the last register are accepted and dropped.
      unique case (irpd_pkg::reg_index_t'(wr_index))
        irpd_pkg::REG_DEVICE_ADDRESS: regs.device_address <= wr_data[15:0];
        irpd_pkg::REG_MODE_CODES:     regs.mode_codes     <= wr_data;
        irpd_pkg::REG_UP_CODES:       regs.up_codes       <= wr_data[31:0];
        irpd_pkg::REG_DOWN_CODES:     regs.down_codes     <= wr_data[31:0];
        irpd_pkg::REG_POWER_CODE:     regs.power_code     <= wr_data[15:0];
        irpd_pkg::REG_HEADER_MIN:     regs.header_min     <= wr_data[15:0];
        irpd_pkg::REG_HEADER_MAX:     regs.header_max     <= wr_data[15:0];
        irpd_pkg::REG_ONE_THRESHOLD:  regs.one_threshold  <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* rtl/irpd_bit_decoder.sv */
// Gap measurement and frame assembly: previous edge, shift register, bit count.
// Depends on irpd_pkg for cfg_t, frame_evt_t and the frame length.
module irpd_bit_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [15:0]           edge_time,
  input  irpd_pkg::cfg_t        cfg,
  output irpd_pkg::frame_evt_t  evt
);

  logic [15:0] previous_edge;
  logic [31:0] shift_bits;
  logic [5:0]  bits_seen;

  logic [15:0] gap;
  logic        is_header;
  logic        bit_value;
  logic [31:0] shift_bits_next;
  logic [5:0]  bits_seen_next;

  always_comb begin
    // The tick counter wraps, so the 16-bit difference is the true gap.
    gap       = edge_time - previous_edge;
    is_header = (gap > cfg.header_min) && (gap < cfg.header_max);
    bit_value = gap > cfg.one_threshold;

    shift_bits_next = shift_bits;
    bits_seen_next  = bits_seen;
    evt.done        = 1'b0;
    evt.code        = '0;

    if (is_header) begin
      shift_bits_next = '0;
      bits_seen_next  = '0;
    end else if (bits_seen < irpd_pkg::FRAME_COUNT) begin
      // MSB first: after the full count the first bit sits at bit 31.
      shift_bits_next = {shift_bits[irpd_pkg::FRAME_BITS-2:0], bit_value};
      bits_seen_next  = bits_seen + 6'd1;
      if (bits_seen == irpd_pkg::LAST_BIT) begin
        evt.done = 1'b1;
        evt.code = shift_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_edge <= '0;
      shift_bits    <= '0;
      bits_seen     <= '0;
    end else if (fire) begin
      previous_edge <= edge_time;
      shift_bits    <= shift_bits_next;
      bits_seen     <= bits_seen_next;
    end
  end

endmodule

/* rtl/irpd_command.sv */
// Button-code matching and the mode and brightness state it drives.
// Depends on irpd_pkg for cfg_t, frame_evt_t, cmd_result_t and the action codes.
module irpd_command (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  irpd_pkg::frame_evt_t   evt,
  input  irpd_pkg::cfg_t         cfg,
  output irpd_pkg::cmd_result_t  res
);

  logic [1:0] mode_level;
  logic [6:0] duty_level;

  logic       addr_ok;
  logic [3:0] mode_hit;
  logic       up_hit;
  logic       down_hit;
  logic       power_hit;

  always_comb begin
    addr_ok = evt.code[31:16] == cfg.device_address;
    for (int i = 0; i < 4; i++) begin
      mode_hit[i] = addr_ok && (evt.code[15:0] == cfg.mode_codes[16*i +: 16]);
    end
    up_hit    = addr_ok && ((evt.code[15:0] == cfg.up_codes[15:0]) ||
                            (evt.code[15:0] == cfg.up_codes[31:16]));
    down_hit  = addr_ok && ((evt.code[15:0] == cfg.down_codes[15:0]) ||
                            (evt.code[15:0] == cfg.down_codes[31:16]));
    power_hit = addr_ok && (evt.code[15:0] == cfg.power_code);

    res.action = irpd_pkg::ACT_NONE;
    res.mode   = mode_level;
    res.duty   = duty_level;

    // Overlapping codes resolve in the order modes, up, down, power.
    if (evt.done) begin
      priority if (mode_hit[0]) begin
        res.action = irpd_pkg::ACT_MODE;
        res.mode   = 2'd0;
      end else if (mode_hit[1]) begin
        res.action = irpd_pkg::ACT_MODE;
        res.mode   = 2'd1;
      end else if (mode_hit[2]) begin
        res.action = irpd_pkg::ACT_MODE;
        res.mode   = 2'd2;
      end else if (mode_hit[3]) begin
        res.action = irpd_pkg::ACT_MODE;
        res.mode   = 2'd3;
      end else if (up_hit) begin
        res.action = irpd_pkg::ACT_UP;
        res.duty   = (duty_level <= irpd_pkg::DUTY_HIGH_LIMIT) ?
                     duty_level + irpd_pkg::DUTY_STEP : irpd_pkg::DUTY_MAX;
      end else if (down_hit) begin
        res.action = irpd_pkg::ACT_DOWN;
        res.duty   = (duty_level >= irpd_pkg::DUTY_STEP) ?
                     duty_level - irpd_pkg::DUTY_STEP : 7'd0;
      end else if (power_hit) begin
        res.action = irpd_pkg::ACT_HALT;
      end else begin
        res.action = irpd_pkg::ACT_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_level <= '0;
      duty_level <= '0;
    end else if (fire) begin
      mode_level <= res.mode;
      duty_level <= res.duty;
    end
  end

endmodule

/* rtl/ir_pulse_distance_decoder_unit.sv */
// Pulse-distance IR remote decoder: one falling-edge timestamp in, one result out.
// Depends on irpd_pkg, irpd_cfg_regs, irpd_bit_decoder, irpd_command and the assert macros.
// An accepted edge goes to the input register, its result then to the result register.
// Throughput: one edge per cycle; the input stalls only when the input register and the
// result register are both full and the output is held.
// Synchronous reset (rst high) empties both registers, clears decoder state and loads defaults.
`include "ir_pulse_distance_decoder_unit_assert.svh"

module ir_pulse_distance_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] edge_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_done,
  output logic [31:0] frame_code,
  output logic [2:0]  action,
  output logic [1:0]  mode_now,
  output logic [6:0]  brightness_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  irpd_pkg::cfg_t        cfg;
  irpd_pkg::frame_evt_t  evt;
  irpd_pkg::cmd_result_t res;

  logic        s1_valid;
  logic [15:0] s1_time;
  logic        s1_go;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;

  irpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  irpd_bit_decoder u_bits (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_go),
    .edge_time (s1_time),
    .cfg       (cfg),
    .evt       (evt)
  );

  irpd_command u_cmd (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_go),
    .evt  (evt),
    .cfg  (cfg),
    .res  (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time <= edge_time;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      frame_done     <= evt.done;
      frame_code     <= evt.code;
      action         <= res.action;
      mode_now       <= res.mode;
      brightness_now <= res.duty;
    end
  end

  `IRPD_ASSERT_NOW(a_empty_output_takes_input, !out_valid, in_ready)
  `IRPD_ASSERT_NOW(a_done_has_action, out_valid && frame_done,
                   action != irpd_pkg::ACT_NONE)
  `IRPD_ASSERT_NOW(a_idle_result_is_quiet, out_valid && !frame_done,
                   (frame_code == 32'd0) && (action == irpd_pkg::ACT_NONE))
  `IRPD_ASSERT_NOW(a_brightness_in_range, out_valid, brightness_now <= irpd_pkg::DUTY_MAX)
  `IRPD_ASSERT_NEXT(a_stage_fills_output, s1_go, out_valid)

endmodule
